FILE: sv/sha_pkg.sv
// Package for the SHA-256 message hasher: round constants, initial hash values
// and the round functions. No dependencies.
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int ChainWords = 8;
    localparam int Rounds = 64;
    localparam int CountWidth = 61;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [0:7];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

endpackage

FILE: sv/sha_stream_if.sv
// Valid/ready channel carrying one word of type T.
// The payload type is given by the parameter T; the interface imports no package.
interface sha_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/sha256_message_hasher_top.sv
// SHA-256 hasher: bytes in, eight digest words out per message, block bytes in one memory.
// Each full block is fetched from the synchronous block memory into the schedule taps,
// run through the rounds and added into the chain values. An end word first writes the
// 0x80 and zero padding one byte per cycle and the bit length as two words, then runs
// one or two such blocks and gives eight output words, one per ready cycle.
// rst_n clears the control state and restores the initial hash values.
module sha256_message_hasher_top
    import sha_pkg::*;
(
    input logic clk,
    input logic rst_n,
    sha_stream_if.sink   in_ch,
    sha_stream_if.source out_ch
);
    localparam logic [3:0] S_IN = 4'd0, S_PAD = 4'd1, S_ZERO = 4'd2, S_LEN = 4'd3,
                           S_CINIT = 4'd4, S_RND = 4'd5, S_CADD = 4'd6, S_OUT = 4'd7,
                           S_RD = 4'd8;

    logic [3:0]  state_reg;
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic        final_reg, second_reg;
    logic        len_done_reg;
    logic [5:0]  rnd_reg;
    logic [3:0]  idx_reg;
    logic [31:0] h_reg [0:7];
    logic [31:0] v_reg [0:7];
    logic [31:0] w_mem [0:15];
    logic [31:0] w_rd_reg;
    logic [31:0] word_reg;
    logic        w_we;
    logic [3:0]  w_wa;
    logic [31:0] w_wd;
    logic [31:0] wt, t1, t2;
    logic [31:0] win [0:15];
    in_word_t    iw;

    assign iw = in_ch.payload;
    assign in_ch.ready = (state_reg == S_IN);

    // Schedule kept in flip-flop taps; block bytes are assembled in the memory.
    always_comb
    begin
        if (rnd_reg < 6'd16)
            wt = win[rnd_reg[3:0]];
        else
            wt = small_s1(win[(rnd_reg[3:0] - 4'd2)]) + win[(rnd_reg[3:0] - 4'd7)]
                 + small_s0(win[(rnd_reg[3:0] - 4'd15)]) + win[rnd_reg[3:0]];
        t1 = v_reg[7] + big_s1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + round_k(rnd_reg) + wt;
        t2 = big_s0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
             ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_wa] <= w_wd;
        w_rd_reg <= w_mem[idx_reg];
    end

    always_comb
    begin
        logic [7:0] b;
        b = (state_reg == S_IN) ? iw.data_byte : ((state_reg == S_PAD) ? 8'h80 : 8'h00);
        w_we = 1'b0;
        w_wa = fill_reg[5:2];
        w_wd = word_reg;
        case (fill_reg[1:0])
            2'd0: w_wd = {b, 24'd0};
            2'd1: w_wd = {word_reg[31:24], b, 16'd0};
            2'd2: w_wd = {word_reg[31:16], b, 8'd0};
            default: w_wd = {word_reg[31:8], b};
        endcase
        if ((state_reg == S_IN && in_ch.valid && iw.byte_valid) || state_reg == S_PAD
            || state_reg == S_ZERO)
            w_we = 1'b1;
        if (state_reg == S_LEN)
        begin
            w_we = 1'b1;
            w_wa = fill_reg[0] ? 4'd15 : 4'd14;
            w_wd = fill_reg[0] ? {count_reg[28:0], 3'b000} : count_reg[60:29];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            fill_reg <= '0;
            count_reg <= '0;
            final_reg <= 1'b0;
            second_reg <= 1'b0;
            rnd_reg <= '0;
            idx_reg <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_h(3'(i));
        end
        else
        begin
            case (state_reg)
                S_IN:
                    if (in_ch.valid)
                    begin
                        if (iw.byte_valid)
                        begin
                            word_reg <= w_wd;
                            fill_reg <= fill_reg + 6'd1;
                            count_reg <= count_reg + 61'd1;
                        end
                        final_reg <= iw.end_of_message;
                        if (iw.byte_valid && fill_reg == 6'd63)
                        begin
                            idx_reg <= '0;
                            state_reg <= S_RD;
                        end
                        else if (iw.end_of_message)
                            state_reg <= S_PAD;
                    end
                S_PAD:
                begin
                    word_reg <= w_wd;
                    second_reg <= (fill_reg > 6'd55);
                    idx_reg <= '0;
                    if (fill_reg == 6'd55)
                    begin
                        fill_reg <= '0;
                        state_reg <= S_LEN;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        state_reg <= (fill_reg == 6'd63) ? S_RD : S_ZERO;
                    end
                end
                S_ZERO:
                begin
                    word_reg <= w_wd;
                    idx_reg <= '0;
                    if (!second_reg && fill_reg == 6'd55)
                    begin
                        fill_reg <= '0;
                        state_reg <= S_LEN;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                            state_reg <= S_RD;
                    end
                end
                S_LEN:
                begin
                    if (fill_reg[0])
                    begin
                        fill_reg <= '0;
                        second_reg <= 1'b0;
                        idx_reg <= '0;
                        state_reg <= S_RD;
                    end
                    else
                        fill_reg <= fill_reg + 6'd1;
                end
                S_RD:
                begin
                    idx_reg <= idx_reg + 4'd1;
                    state_reg <= S_CINIT;
                end
                S_CINIT:
                begin
                    win[idx_reg - 4'd1] <= w_rd_reg;
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg == 4'd0)
                    begin
                        for (int i = 0; i < 8; i++)
                            v_reg[i] <= h_reg[i];
                        rnd_reg <= '0;
                        state_reg <= S_RND;
                    end
                end
                S_RND:
                begin
                    win[rnd_reg[3:0]] <= wt;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= S_CADD;
                end
                S_CADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    idx_reg <= '0;
                    if (!final_reg)
                        state_reg <= S_IN;
                    else if (second_reg)
                    begin
                        fill_reg <= '0;
                        second_reg <= 1'b0;
                        state_reg <= S_ZERO;
                    end
                    else if (!len_done_reg)
                        state_reg <= S_PAD;
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ch.ready)
                    begin
                        if (idx_reg == 4'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= init_h(3'(i));
                            idx_reg <= '0;
                            fill_reg <= '0;
                            count_reg <= '0;
                            final_reg <= 1'b0;
                            state_reg <= S_IN;
                        end
                        else
                        begin
                            for (int i = 0; i < 7; i++)
                                h_reg[i] <= h_reg[i + 1];
                            idx_reg <= idx_reg + 4'd1;
                        end
                    end
                default: state_reg <= S_IN;
            endcase
        end
    end

    // After a final block: if the end word completed a full block, padding still
    // has to start; once the length block is done, output follows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_done_reg <= 1'b0;
        else if (state_reg == S_LEN)
            len_done_reg <= 1'b1;
        else if (state_reg == S_OUT && out_ch.ready && idx_reg == 4'd7)
            len_done_reg <= 1'b0;
    end

    out_word_t ow;
    always_comb
    begin
        ow.digest_word = h_reg[0];
        ow.word_index = idx_reg[2:0];
        ow.last_word = (idx_reg == 4'd7);
    end
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.payload = ow;

endmodule

FILE: sv/sha_checker.sv
// Port-level checks for the SHA-256 hasher, bound to the top level.
// Depends on sha_pkg.
module sha_checker
    import sha_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_payload
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken during digest output");
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_payload.last_word |=>
        out_valid && out_payload.word_index == $past(out_payload.word_index) + 3'd1)
        else $error("digest words out of order");
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_payload.last_word == (out_payload.word_index == 3'd7)))
        else $error("last word flag wrong");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("stalled digest word changed");
endmodule

bind sha256_message_hasher_top sha_checker u_sha_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload));
